FILE: sv/tapdf_pkg.sv
// Shared types, constants and helpers for the three-axis PID unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tapdf_pkg;

    localparam int AXES       = 3;
    localparam int AXIS_W     = 2;
    localparam int FX_W       = 32;
    localparam int FRAC_W     = 16;
    localparam int GAIN_W     = 31;
    localparam int SMOOTH_W   = 17;
    localparam int TS_W       = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_W       = 2 * AXES * FX_W;
    localparam int OUT_W      = AXES * FX_W;

    // shared multiplier: signed 33-bit operand by unsigned 16-bit digit
    localparam int MA_W   = FX_W + 1;
    localparam int MB_W   = 16;
    localparam int PROD_W = MA_W + MB_W + 1;
    localparam int ACC_W  = 66;
    localparam int DSUM_W = 50;

    localparam logic [CFG_IDX_W-1:0] REG_P_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_I_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_I_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_D_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_D_SMOOTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TS       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TS_RECIP = 3'd6;

    localparam logic [GAIN_W-1:0]   RST_P_GAIN   = 31'd32768000;
    localparam logic [GAIN_W-1:0]   RST_I_GAIN   = 31'd0;
    localparam logic [GAIN_W-1:0]   RST_I_LIMIT  = 31'd0;
    localparam logic [GAIN_W-1:0]   RST_D_GAIN   = 31'd1310720;
    localparam logic [SMOOTH_W-1:0] RST_D_SMOOTH = 17'd65536;
    localparam logic [TS_W-1:0]     RST_TS       = 16'd1311;
    localparam logic [GAIN_W-1:0]   RST_TS_RECIP = 31'd3276800;

    localparam logic [SMOOTH_W-1:0] FX_ONE = 17'd65536;

    typedef logic signed [FX_W-1:0] t_fx;

    typedef struct packed {
        logic [GAIN_W-1:0]   p_gain;
        logic [GAIN_W-1:0]   i_gain;
        logic [GAIN_W-1:0]   i_limit;
        logic [GAIN_W-1:0]   d_gain;
        logic [SMOOTH_W-1:0] d_smooth;
        logic [TS_W-1:0]     time_step;
        logic [GAIN_W-1:0]   time_step_recip;
    } t_cfg;

    typedef struct packed {
        logic            en;
        logic            clr;
        logic            sh;
        logic [MA_W-1:0] a;
        logic [MB_W-1:0] b;
    } t_mac_op;

    // saturate a wide signed value to 32 bits
    function automatic t_fx sat32(input logic signed [ACC_W-1:0] x);
        t_fx res;
        if (&x[ACC_W-1:FX_W-1] || ~|x[ACC_W-1:FX_W-1]) begin
            res = x[FX_W-1:0];
        end else if (x[ACC_W-1]) begin
            res = {1'b1, {(FX_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(FX_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: sv/tapdf_cfg.sv
// Configuration register file for the PID unit.
// Depends on tapdf_pkg for register indices, reset values and t_cfg.
`timescale 1ns / 1ps
`default_nettype none

module tapdf_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [tapdf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tapdf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output tapdf_pkg::t_cfg                       o_cfg
);
    import tapdf_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.p_gain          <= RST_P_GAIN;
            r_cfg.i_gain          <= RST_I_GAIN;
            r_cfg.i_limit         <= RST_I_LIMIT;
            r_cfg.d_gain          <= RST_D_GAIN;
            r_cfg.d_smooth        <= RST_D_SMOOTH;
            r_cfg.time_step       <= RST_TS;
            r_cfg.time_step_recip <= RST_TS_RECIP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_P_GAIN:   r_cfg.p_gain          <= i_cfg_data[GAIN_W-1:0];
                REG_I_GAIN:   r_cfg.i_gain          <= i_cfg_data[GAIN_W-1:0];
                REG_I_LIMIT:  r_cfg.i_limit         <= i_cfg_data[GAIN_W-1:0];
                REG_D_GAIN:   r_cfg.d_gain          <= i_cfg_data[GAIN_W-1:0];
                REG_D_SMOOTH: r_cfg.d_smooth        <= i_cfg_data[SMOOTH_W-1:0];
                REG_TS:       r_cfg.time_step       <= i_cfg_data[TS_W-1:0];
                REG_TS_RECIP: r_cfg.time_step_recip <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sv/tapdf_mac.sv
// Shared multiply-accumulate unit: 33x16 signed-by-unsigned product,
// registered, then added (optionally << 16) into a 66-bit accumulator.
// Depends on tapdf_pkg for widths and t_mac_op.
`timescale 1ns / 1ps
`default_nettype none

module tapdf_mac (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire tapdf_pkg::t_mac_op          i_op,
    output logic signed [tapdf_pkg::ACC_W-1:0] o_acc
);
    import tapdf_pkg::*;

    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_en;
    logic                     r_clr;
    logic                     r_sh;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  addend;

    assign n_prod   = $signed(i_op.a) * $signed({1'b0, i_op.b});
    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign addend   = r_sh ? (prod_ext <<< FRAC_W) : prod_ext;
    assign o_acc    = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0;
        end else begin
            r_en <= i_op.en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_clr  <= i_op.clr;
        r_sh   <= i_op.sh;
        if (r_en) begin
            r_acc <= r_clr ? addend : r_acc + addend;
        end
    end

endmodule

`default_nettype wire

FILE: sv/tapdf_core.sv
// Per-axis PID sequencer: walks each axis through a fixed schedule of
// partial products on the shared MAC and keeps the per-axis state.
// Depends on tapdf_pkg and tapdf_mac.
`timescale 1ns / 1ps
`default_nettype none

module tapdf_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire tapdf_pkg::t_cfg             i_cfg,
    input  wire logic                        i_start,
    input  wire logic [tapdf_pkg::IN_W-1:0]  i_item,
    input  wire logic                        i_hold,
    output logic                             o_busy,
    output logic                             o_done,
    output logic [tapdf_pkg::OUT_W-1:0]      o_drive
);
    import tapdf_pkg::*;

    localparam logic [4:0] SP_ERR    = 5'd0;
    localparam logic [4:0] SP_MUL_TS = 5'd1;
    localparam logic [4:0] SP_MUL_R0 = 5'd2;
    localparam logic [4:0] SP_MUL_R1 = 5'd3;   // also sums the integral
    localparam logic [4:0] SP_CLAMP  = 5'd4;
    localparam logic [4:0] SP_RAW    = 5'd5;
    localparam logic [4:0] SP_MUL_S0 = 5'd6;
    localparam logic [4:0] SP_MUL_S1 = 5'd7;
    localparam logic [4:0] SP_MUL_V0 = 5'd8;
    localparam logic [4:0] SP_MUL_V1 = 5'd9;
    localparam logic [4:0] SP_MUL_P0 = 5'd10;
    localparam logic [4:0] SP_MUL_P1 = 5'd11;  // also takes the smoothed value
    localparam logic [4:0] SP_MUL_I0 = 5'd12;
    localparam logic [4:0] SP_MUL_I1 = 5'd13;  // also takes the P term
    localparam logic [4:0] SP_MUL_D0 = 5'd14;
    localparam logic [4:0] SP_MUL_D1 = 5'd15;  // also adds the I term
    localparam logic [4:0] SP_WAIT   = 5'd16;
    localparam logic [4:0] SP_DTERM  = 5'd17;
    localparam logic [4:0] SP_STORE  = 5'd18;
    localparam logic [4:0] SP_DONE   = 5'd19;

    localparam logic [AXIS_W-1:0] AX_LAST = AXIS_W'(AXES - 1);

    logic                     r_run;
    logic [4:0]               r_step;
    logic [AXIS_W-1:0]        r_axis;

    t_fx                      r_err;
    t_fx                      r_integ;
    t_fx                      r_raw;
    t_fx                      r_sm;
    logic signed [FX_W:0]     r_diff;
    logic signed [FX_W+1:0]   r_isum;
    logic signed [DSUM_W-1:0] r_dsum;

    t_fx                      r_integ_st [AXES];
    t_fx                      r_last     [AXES];
    t_fx                      r_smd      [AXES];
    t_fx                      r_drive    [AXES];

    t_mac_op                  mac_op;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  acc_sh;
    t_fx                      cur;
    t_fx                      goal;
    logic signed [FX_W:0]     gdiff;
    logic [SMOOTH_W-1:0]      w;
    logic [SMOOTH_W-1:0]      v;
    logic signed [FX_W+1:0]   lim_pos;
    logic signed [FX_W+1:0]   lim_neg;
    t_fx                      smd_cur;

    tapdf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (mac_op),
        .o_acc   (acc)
    );

    assign cur     = i_item[r_axis * FX_W +: FX_W];
    assign goal    = i_item[(AXES + r_axis) * FX_W +: FX_W];
    assign gdiff   = {goal[FX_W-1], goal} - {cur[FX_W-1], cur};
    assign acc_sh  = acc >>> FRAC_W;
    assign w       = (i_cfg.d_smooth > FX_ONE) ? FX_ONE : i_cfg.d_smooth;
    assign v       = FX_ONE - w;
    assign lim_pos = {3'b000, i_cfg.i_limit};
    assign lim_neg = -lim_pos;
    assign smd_cur = r_smd[r_axis];

    assign o_busy = r_run;
    assign o_done = r_run && (r_step == SP_DONE) && !i_hold;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            o_drive[a * FX_W +: FX_W] = r_drive[a];
        end
    end

    // operand selection for the shared MAC
    always_comb begin
        mac_op    = '0;
        mac_op.en = r_run;
        case (r_step)
            SP_MUL_TS: begin
                mac_op.clr = 1'b1;
                mac_op.a   = {r_err[FX_W-1], r_err};
                mac_op.b   = i_cfg.time_step;
            end
            SP_MUL_R0: begin
                mac_op.clr = 1'b1;
                mac_op.a   = r_diff;
                mac_op.b   = i_cfg.time_step_recip[MB_W-1:0];
            end
            SP_MUL_R1: begin
                mac_op.sh = 1'b1;
                mac_op.a  = r_diff;
                mac_op.b  = {1'b0, i_cfg.time_step_recip[GAIN_W-1:MB_W]};
            end
            SP_MUL_S0: begin
                mac_op.clr = 1'b1;
                mac_op.a   = {smd_cur[FX_W-1], smd_cur};
                mac_op.b   = w[MB_W-1:0];
            end
            SP_MUL_S1: begin
                mac_op.sh = 1'b1;
                mac_op.a  = {smd_cur[FX_W-1], smd_cur};
                mac_op.b  = {{(MB_W-1){1'b0}}, w[SMOOTH_W-1]};
            end
            SP_MUL_V0: begin
                mac_op.a = {r_raw[FX_W-1], r_raw};
                mac_op.b = v[MB_W-1:0];
            end
            SP_MUL_V1: begin
                mac_op.sh = 1'b1;
                mac_op.a  = {r_raw[FX_W-1], r_raw};
                mac_op.b  = {{(MB_W-1){1'b0}}, v[SMOOTH_W-1]};
            end
            SP_MUL_P0: begin
                mac_op.clr = 1'b1;
                mac_op.a   = {r_err[FX_W-1], r_err};
                mac_op.b   = i_cfg.p_gain[MB_W-1:0];
            end
            SP_MUL_P1: begin
                mac_op.sh = 1'b1;
                mac_op.a  = {r_err[FX_W-1], r_err};
                mac_op.b  = {1'b0, i_cfg.p_gain[GAIN_W-1:MB_W]};
            end
            SP_MUL_I0: begin
                mac_op.clr = 1'b1;
                mac_op.a   = {r_integ[FX_W-1], r_integ};
                mac_op.b   = i_cfg.i_gain[MB_W-1:0];
            end
            SP_MUL_I1: begin
                mac_op.sh = 1'b1;
                mac_op.a  = {r_integ[FX_W-1], r_integ};
                mac_op.b  = {1'b0, i_cfg.i_gain[GAIN_W-1:MB_W]};
            end
            SP_MUL_D0: begin
                mac_op.clr = 1'b1;
                mac_op.a   = {r_sm[FX_W-1], r_sm};
                mac_op.b   = i_cfg.d_gain[MB_W-1:0];
            end
            SP_MUL_D1: begin
                mac_op.sh = 1'b1;
                mac_op.a  = {r_sm[FX_W-1], r_sm};
                mac_op.b  = {1'b0, i_cfg.d_gain[GAIN_W-1:MB_W]};
            end
            default: begin
                mac_op.en = 1'b0;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_step <= SP_ERR;
            r_axis <= '0;
        end else if (!r_run) begin
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= SP_ERR;
                r_axis <= '0;
            end
        end else begin
            case (r_step)
                SP_STORE: begin
                    if (r_axis == AX_LAST) begin
                        r_step <= SP_DONE;
                    end else begin
                        r_axis <= r_axis + 1'b1;
                        r_step <= SP_ERR;
                    end
                end
                SP_DONE: begin
                    if (!i_hold) begin
                        r_run <= 1'b0;
                    end
                end
                default: begin
                    r_step <= r_step + 1'b1;
                end
            endcase
        end
    end

    // per-axis state, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_integ_st[a] <= '0;
                r_last[a]     <= '0;
                r_smd[a]      <= '0;
            end
        end else if (r_run && r_step == SP_STORE) begin
            r_integ_st[r_axis] <= r_integ;
            r_last[r_axis]     <= r_err;
            r_smd[r_axis]      <= r_sm;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (r_run) begin
            case (r_step)
                SP_ERR: begin
                    r_err <= sat32({{(ACC_W-FX_W-1){gdiff[FX_W]}}, gdiff});
                end
                SP_MUL_TS: begin
                    r_diff <= {r_err[FX_W-1], r_err} - {r_last[r_axis][FX_W-1], r_last[r_axis]};
                end
                SP_MUL_R1: begin
                    r_isum <= {{2{r_integ_st[r_axis][FX_W-1]}}, r_integ_st[r_axis]}
                            + acc_sh[FX_W+1:0];
                end
                SP_CLAMP: begin
                    if (r_isum > lim_pos) begin
                        r_integ <= lim_pos[FX_W-1:0];
                    end else if (r_isum < lim_neg) begin
                        r_integ <= lim_neg[FX_W-1:0];
                    end else begin
                        r_integ <= r_isum[FX_W-1:0];
                    end
                end
                SP_RAW: begin
                    r_raw <= sat32(acc_sh);
                end
                SP_MUL_P1: begin
                    // weighted mean of two 32-bit values stays in range
                    r_sm <= acc_sh[FX_W-1:0];
                end
                SP_MUL_I1: begin
                    r_dsum <= acc_sh[DSUM_W-1:0];
                end
                SP_MUL_D1, SP_DTERM: begin
                    r_dsum <= r_dsum + acc_sh[DSUM_W-1:0];
                end
                SP_STORE: begin
                    r_drive[r_axis] <= sat32({{(ACC_W-DSUM_W){r_dsum[DSUM_W-1]}}, r_dsum});
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sv/three_axis_pid_filtered_derivative_unit.sv
// s_axis_tready is low while the core is busy, so a new item is taken only
// once the last is done; each axis runs 19 sequencer steps, 13 of them
// partial products on the single shared 33x16 multiplier.
// The output register lets the next beat in while a result waits.
// Reset: synchronous, active low; config returns to defaults, all per-axis
// integral, last error and smoothed derivative state is cleared to zero.
`timescale 1ns / 1ps
`default_nettype none

module three_axis_pid_filtered_derivative_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // cur_x, cur_y, cur_z, goal_x, goal_y, goal_z (32 bits each, lowest first)
    input  wire logic [tapdf_pkg::IN_W-1:0]       s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // drive_x, drive_y, drive_z (32 bits each, lowest first)
    output logic [tapdf_pkg::OUT_W-1:0]           m_axis_tdata,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [tapdf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tapdf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tapdf_pkg::*;

    t_cfg             cfg;
    logic [IN_W-1:0]  r_item;
    logic [OUT_W-1:0] r_out;
    logic             r_out_valid;
    logic             core_busy;
    logic             core_done;
    logic             hold;
    logic             in_beat;
    logic [OUT_W-1:0] drive;

    assign s_axis_tready = !core_busy;
    assign in_beat       = s_axis_tvalid && !core_busy;
    assign hold          = r_out_valid && !m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    tapdf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tapdf_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_start (in_beat),
        .i_item  (r_item),
        .i_hold  (hold),
        .o_busy  (core_busy),
        .o_done  (core_done),
        .o_drive (drive)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_item <= s_axis_tdata;
        end
        if (core_done) begin
            r_out <= drive;
        end
    end

endmodule

`default_nettype wire
